[rtl/core/mcfp_pkg.sv]
// Shared constants and types for the motor command field parser.
package mcfp_pkg;

  localparam int unsigned FIELD_DIGITS = 4;
  localparam int unsigned NUM_FIELDS   = 3;

  localparam logic [7:0] SEP_BYTE   = 8'h2C;
  localparam logic [7:0] END_BYTE   = 8'h23;
  localparam logic [7:0] MINUS_BYTE = 8'h2D;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;

  localparam logic [7:0] DUTY_MAX    = 8'd255;
  localparam logic [7:0] BLINK_DUTY  = 8'd255;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef struct packed {
    logic take;
    logic is_sep;
    logic is_end;
    logic is_minus;
  } byte_ctl_t;

endpackage

[rtl/core/mcfp_field_acc.sv]
// Field accumulator: decimal digit accumulation, sign and the field store.
module mcfp_field_acc #(
  parameter int unsigned FIELD_DIGITS = mcfp_pkg::FIELD_DIGITS,
  localparam int unsigned LIMIT = 10 ** FIELD_DIGITS - 1,
  localparam int unsigned MAG_W = $clog2(LIMIT + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mcfp_pkg::byte_ctl_t   ctl,
  input  logic [7:0]            byte_value,
  output logic                  fin_neg [mcfp_pkg::NUM_FIELDS],
  output logic [MAG_W-1:0]      fin_mag [mcfp_pkg::NUM_FIELDS]
);

  localparam int unsigned SUM_W = MAG_W + 4;
  localparam logic [SUM_W-1:0] LIMIT_EXT = SUM_W'(LIMIT);

  logic [MAG_W-1:0] acc;
  logic             neg;
  logic             started;
  logic [1:0]       idx;
  logic             st_neg [mcfp_pkg::NUM_FIELDS];
  logic [MAG_W-1:0] st_mag [mcfp_pkg::NUM_FIELDS];

  logic [3:0]       dig;
  logic [SUM_W-1:0] sum;
  logic [MAG_W-1:0] acc_next;

  always_comb begin
    if (byte_value inside {[mcfp_pkg::ZERO_CHAR:mcfp_pkg::NINE_CHAR]}) begin
      dig = 4'(byte_value - mcfp_pkg::ZERO_CHAR);
    end else begin
      dig = 4'd0;
    end
    sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + SUM_W'(dig);
    acc_next = (sum > LIMIT_EXT) ? MAG_W'(LIMIT) : sum[MAG_W-1:0];
  end

  // current field folded into the store, as it stands once finished
  always_comb begin
    for (int i = 0; i < mcfp_pkg::NUM_FIELDS; i++) begin
      fin_neg[i] = st_neg[i];
      fin_mag[i] = st_mag[i];
    end
    if (idx != 2'(mcfp_pkg::NUM_FIELDS)) begin
      fin_neg[idx] = neg;
      fin_mag[idx] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      neg     <= 1'b0;
      started <= 1'b0;
      idx     <= '0;
      for (int i = 0; i < mcfp_pkg::NUM_FIELDS; i++) begin
        st_neg[i] <= 1'b0;
        st_mag[i] <= '0;
      end
    end else if (ctl.take) begin
      if (ctl.is_end) begin
        acc     <= '0;
        neg     <= 1'b0;
        started <= 1'b0;
        idx     <= '0;
        for (int i = 0; i < mcfp_pkg::NUM_FIELDS; i++) begin
          st_neg[i] <= 1'b0;
          st_mag[i] <= '0;
        end
      end else if (ctl.is_sep) begin
        for (int i = 0; i < mcfp_pkg::NUM_FIELDS; i++) begin
          st_neg[i] <= fin_neg[i];
          st_mag[i] <= fin_mag[i];
        end
        if (idx != 2'(mcfp_pkg::NUM_FIELDS)) begin
          idx <= idx + 2'd1;
        end
        acc     <= '0;
        neg     <= 1'b0;
        started <= 1'b0;
      end else if (ctl.is_minus && !started) begin
        neg     <= 1'b1;
        started <= 1'b1;
      end else begin
        acc     <= acc_next;
        started <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/mcfp_result_fmt.sv]
// Result formatting: direction, saturated duty and command kind per message.
module mcfp_result_fmt #(
  parameter int unsigned FIELD_DIGITS = mcfp_pkg::FIELD_DIGITS,
  localparam int unsigned LIMIT = 10 ** FIELD_DIGITS - 1,
  localparam int unsigned MAG_W = $clog2(LIMIT + 1)
) (
  input  logic               fin_neg [mcfp_pkg::NUM_FIELDS],
  input  logic [MAG_W-1:0]   fin_mag [mcfp_pkg::NUM_FIELDS],
  output logic               rev     [mcfp_pkg::NUM_FIELDS],
  output logic [7:0]         duty    [mcfp_pkg::NUM_FIELDS],
  output mcfp_pkg::kind_t    kind
);

  localparam int unsigned EXT_W = (MAG_W > 9) ? MAG_W : 9;
  localparam logic [EXT_W-1:0] DUTY_MAX_EXT   = EXT_W'(mcfp_pkg::DUTY_MAX);
  localparam logic [EXT_W-1:0] BLINK_DUTY_EXT = EXT_W'(mcfp_pkg::BLINK_DUTY);

  logic [EXT_W-1:0] ext [mcfp_pkg::NUM_FIELDS];
  logic             all_start;
  logic             all_stop;

  always_comb begin
    all_start = 1'b1;
    all_stop  = 1'b1;
    for (int i = 0; i < mcfp_pkg::NUM_FIELDS; i++) begin
      ext[i]  = EXT_W'(fin_mag[i]);
      rev[i]  = fin_neg[i] && (ext[i] != '0);
      duty[i] = (ext[i] > DUTY_MAX_EXT) ? mcfp_pkg::DUTY_MAX : ext[i][7:0];
      all_start = all_start && fin_neg[i] && (ext[i] == BLINK_DUTY_EXT);
      all_stop  = all_stop && (ext[i] == '0);
    end
    if (all_start) begin
      kind = mcfp_pkg::KIND_START;
    end else if (all_stop) begin
      kind = mcfp_pkg::KIND_STOP;
    end else begin
      kind = mcfp_pkg::KIND_OTHER;
    end
  end

endmodule

[rtl/core/motor_command_field_parser.sv]
// Top level of the motor command field parser: input register, parser, result register.
//
// Input channel: in_valid / in_stall carry one received byte per beat on byte_value.
// Messages are signed decimal fields split by ',' and closed by '#'; a leading '-'
// makes a field negative, other non-digit bytes count as zero, magnitudes saturate
// at 10^FIELD_DIGITS - 1. Fields past the third are dropped, missing ones read zero.
// Output channel: out_valid / out_stall carry one result beat per '#': direction and
// duty (saturated at 255) for left, right and rear motors plus command_kind.
// Throughput: one byte per cycle while in_stall is low; the accumulate (acc*10 + digit,
// saturating compare) is combinational between the input register and state registers.
// A '#' passes the input register, then the result register, which raises out_valid.
// Stall: while out_stall holds a result, non-terminating bytes keep flowing; a
// following '#' waits in the input register and in_stall rises until the result
// beat is taken.
// Reset (rst, synchronous): both channels empty, parser state cleared to an empty
// message.
module motor_command_field_parser #(
  parameter int unsigned FIELD_DIGITS = mcfp_pkg::FIELD_DIGITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      byte_value,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            left_reverse,
  output logic [7:0]      left_duty,
  output logic            right_reverse,
  output logic [7:0]      right_duty,
  output logic            rear_reverse,
  output logic [7:0]      rear_duty,
  output logic [1:0]      command_kind
);

  localparam int unsigned LIMIT = 10 ** FIELD_DIGITS - 1;
  localparam int unsigned MAG_W = $clog2(LIMIT + 1);

  logic                in_vld_r;
  logic [7:0]          byte_r;
  logic                advance;
  mcfp_pkg::byte_ctl_t ctl;

  logic                fin_neg [mcfp_pkg::NUM_FIELDS];
  logic [MAG_W-1:0]    fin_mag [mcfp_pkg::NUM_FIELDS];
  logic                rev     [mcfp_pkg::NUM_FIELDS];
  logic [7:0]          duty    [mcfp_pkg::NUM_FIELDS];
  mcfp_pkg::kind_t     kind;

  always_comb begin
    ctl.is_sep   = (byte_r == mcfp_pkg::SEP_BYTE);
    ctl.is_end   = (byte_r == mcfp_pkg::END_BYTE);
    ctl.is_minus = (byte_r == mcfp_pkg::MINUS_BYTE);
    advance      = in_vld_r && (!ctl.is_end || !out_valid || !out_stall);
    ctl.take     = advance;
  end

  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= byte_value;
    end
  end

  mcfp_field_acc #(
    .FIELD_DIGITS (FIELD_DIGITS)
  ) u_field_acc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .byte_value (byte_r),
    .fin_neg    (fin_neg),
    .fin_mag    (fin_mag)
  );

  mcfp_result_fmt #(
    .FIELD_DIGITS (FIELD_DIGITS)
  ) u_result_fmt (
    .fin_neg (fin_neg),
    .fin_mag (fin_mag),
    .rev     (rev),
    .duty    (duty),
    .kind    (kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && ctl.is_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctl.is_end) begin
      left_reverse  <= rev[0];
      left_duty     <= duty[0];
      right_reverse <= rev[1];
      right_duty    <= duty[1];
      rear_reverse  <= rev[2];
      rear_duty     <= duty[2];
      command_kind  <= kind;
    end
  end

  // start blink result carries full reverse on every motor
  a_start_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command_kind == mcfp_pkg::KIND_START) |->
      left_reverse && right_reverse && rear_reverse &&
      (left_duty == mcfp_pkg::BLINK_DUTY) && (right_duty == mcfp_pkg::BLINK_DUTY) &&
      (rear_duty == mcfp_pkg::BLINK_DUTY))
    else $error("start kind with mismatching motor fields");

  a_stop_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command_kind == mcfp_pkg::KIND_STOP) |->
      !left_reverse && !right_reverse && !rear_reverse &&
      (left_duty == 8'd0) && (right_duty == 8'd0) && (rear_duty == 8'd0))
    else $error("stop kind with non-zero motor fields");

  a_reverse_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (left_reverse || right_reverse || rear_reverse) |->
      (!left_reverse || (left_duty != 8'd0)) &&
      (!right_reverse || (right_duty != 8'd0)) &&
      (!rear_reverse || (rear_duty != 8'd0)))
    else $error("reverse flagged on a zero duty");

  a_end_held: assert property (@(posedge clk) disable iff (rst)
    in_vld_r && ctl.is_end && out_valid && out_stall |=>
      in_vld_r && (byte_r == mcfp_pkg::END_BYTE))
    else $error("terminating byte lost while result stalled");

endmodule
